### rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Item structs, escape phase codes, queue entry format and hex decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  // Character codes
  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SpaceChar = 8'h20;

  // Most decoded bytes one source byte can cause
  localparam int unsigned MaxResults = 3;

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Input and output items
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Escape state
  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  // One queue entry: the decoded bytes of one source byte
  typedef struct packed {
    logic [1:0]                 cnt;    // 1 to MaxResults
    logic                       last;   // final entry of the string
    logic [MaxResults-1:0][7:0] bytes;  // bytes[0] goes out first
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming form-urlencoded decoder
// '+' becomes a space, '%' and two hex digits become one byte, malformed
// or unfinished escapes pass through literally.
//
//   channel | direction | payload                       | handshake
//   --------+-----------+-------------------------------+---------------------
//   in      | input     | in_byte[7:0], in_last         | in_valid_i/in_ready_o
//   out     | output    | out_byte[7:0], out_last       | out_valid_o/out_ready_i
//
// One source byte is taken per cycle while the entry queue has room.
// Decoded bytes leave the queue head through an output register, one per cycle
// while out_ready_i allows, so a source byte causing two or three bytes holds
// the back end longer; the four-entry queue absorbs these bursts.
// Reset clears the escape state, the queue and the output register.
// Output stalls back up through the queue to in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  upd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output upd_pkg::out_item_t  out_data_o
);

  upd_pkg::entry_t     push_entry;
  upd_pkg::entry_t     head;
  upd_pkg::q_status_t  q_status;
  logic                push;
  logic                pop;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  upd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front: escape tracking and classification
// Takes one source byte per cycle unless the queue is full, tracks the pending
// escape and builds the queue entry with the decoded bytes the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  upd_pkg::in_item_t   in_data_i,
  input  upd_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output upd_pkg::entry_t     entry_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;

  logic [7:0]      b;
  logic [4:0]      hex_b;
  logic [4:0]      hex_h;
  logic            do_fresh;
  logic [1:0]      n;
  logic            accept;

  assign b          = in_data_i.in_byte;
  assign hex_b      = upd_pkg::hex_decode(b);
  assign hex_h      = upd_pkg::hex_decode(held_q);
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Decode of the current byte against the pending escape
  always_comb begin
    phase_d       = phase_q;
    held_d        = held_q;
    do_fresh      = 1'b0;
    n             = 2'd0;
    entry_o.bytes = '0;

    case (phase_q)
      upd_pkg::PhPct: begin
        if (hex_b[4]) begin
          phase_d = upd_pkg::PhDigit;
          held_d  = b;
        end else begin
          entry_o.bytes[0] = upd_pkg::PctChar;
          n                = 2'd1;
          do_fresh         = 1'b1;
        end
      end
      upd_pkg::PhDigit: begin
        if (hex_b[4]) begin
          entry_o.bytes[0] = {hex_h[3:0], hex_b[3:0]};
          n                = 2'd1;
          phase_d          = upd_pkg::PhIdle;
        end else begin
          entry_o.bytes[0] = upd_pkg::PctChar;
          entry_o.bytes[1] = held_q;
          n                = 2'd2;
          do_fresh         = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // Byte with no escape pending
    if (do_fresh) begin
      phase_d = upd_pkg::PhIdle;
      if (b == upd_pkg::PctChar) begin
        phase_d = upd_pkg::PhPct;
      end else begin
        entry_o.bytes[n] = (b == upd_pkg::PlusChar) ? upd_pkg::SpaceChar : b;
        n                = n + 2'd1;
      end
    end

    // End of string: flush what is pending literally
    if (in_data_i.in_last) begin
      if (phase_d == upd_pkg::PhPct) begin
        entry_o.bytes[n] = upd_pkg::PctChar;
        n                = n + 2'd1;
      end else if (phase_d == upd_pkg::PhDigit) begin
        entry_o.bytes[n]        = upd_pkg::PctChar;
        entry_o.bytes[n + 2'd1] = held_d;
        n                       = n + 2'd2;
      end
      phase_d = upd_pkg::PhIdle;
      held_d  = 8'd0;
    end

    entry_o.cnt  = n;
    entry_o.last = in_data_i.in_last;
    push_o       = accept && (n != 2'd0);
  end

  // Escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PhIdle;
      held_q  <= 8'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // A final byte always yields at least one decoded byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.in_last) |-> push_o)
    else $error("final byte produced no entry");

  // The escape always closes at the end of a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.in_last) |=> (phase_q == upd_pkg::PhIdle))
    else $error("escape left pending after final byte");

endmodule

`default_nettype wire

### rtl/upd_fifo.sv
// ----------------------------------------------------------------------------
// upd_fifo: entry queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  upd_pkg::entry_t     entry_i,
  input  wire                 pop_i,
  output upd_pkg::entry_t     head_o,
  output upd_pkg::q_status_t  status_o
);

  upd_pkg::entry_t                mem_q [upd_pkg::QDepth];
  logic [upd_pkg::QPtrW-1:0]      wptr_q, rptr_q;
  logic [upd_pkg::QPtrW:0]        count_q;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == (upd_pkg::QPtrW+1)'(upd_pkg::QDepth));
  assign head_o         = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (upd_pkg::QPtrW+1)'(upd_pkg::QDepth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back: byte serialiser
// Sends head entry bytes via an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  upd_pkg::entry_t     head_i,
  input  upd_pkg::q_status_t  q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output upd_pkg::out_item_t  out_data_o
);

  logic                 valid_q;
  upd_pkg::out_item_t   data_q, data_d;
  logic [1:0]           sel_q, sel_d;
  logic                 load;
  logic                 at_end;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Pick the next byte of the head entry
  always_comb begin
    load            = (!valid_q || out_ready_i) && !q_status_i.empty;
    at_end          = (sel_q == head_i.cnt - 2'd1);
    data_d.out_byte = head_i.bytes[sel_q];
    data_d.out_last = head_i.last && at_end;
    pop_o           = load && at_end;
    sel_d           = sel_q;
    if (load) begin
      sel_d = at_end ? 2'd0 : sel_q + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 2'd0;
    end else begin
      sel_q <= sel_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  // The byte index stays inside the head entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> (sel_q < head_i.cnt))
    else $error("byte index beyond head entry");

endmodule

`default_nettype wire

### dv/upd_decode_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_decode_check: decoded byte checker for url_percent_decoder
// Watches both channels, decodes every accepted source item on its own copy
// of the escape state and compares each accepted out item in order.
// ----------------------------------------------------------------------------
module upd_decode_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  upd_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  upd_pkg::out_item_t out_data_i,
  output int                 err_cnt_o,
  output int                 expect_cnt_o,
  output int                 res_cnt_o
);

  // Predicted escape state
  upd_pkg::phase_e     phase_q;
  logic [7:0]          held_q;

  // Decoded bytes still to come out, oldest first
  upd_pkg::out_item_t  decoded_q[$];
  int                  errs;
  int                  seen;

  // Hex digit value, bit 4 flags a valid digit
  function automatic logic [4:0] digit_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  // Decode one source item and queue the bytes it releases
  task automatic decode_source(input upd_pkg::in_item_t it);
    logic [7:0] dec [0:2];
    int         n;
    logic       again;
    logic [4:0] cur;
    logic [4:0] first;
    n     = 0;
    again = 1'b0;
    cur   = digit_val(it.in_byte);
    first = digit_val(held_q);
    case (phase_q)
      upd_pkg::PhPct: begin
        if (cur[4]) begin
          held_q  = it.in_byte;
          phase_q = upd_pkg::PhDigit;
        end else begin
          dec[n]  = upd_pkg::PctChar;
          n++;
          phase_q = upd_pkg::PhIdle;
          again   = 1'b1;
        end
      end
      upd_pkg::PhDigit: begin
        phase_q = upd_pkg::PhIdle;
        if (cur[4]) begin
          dec[n] = {first[3:0], cur[3:0]};
          n++;
        end else begin
          dec[n] = upd_pkg::PctChar;
          n++;
          dec[n] = held_q;
          n++;
          again  = 1'b1;
        end
      end
      default: begin
        phase_q = upd_pkg::PhIdle;
        again   = 1'b1;
      end
    endcase
    // malformed or no escape pending: the current byte starts afresh
    if (again) begin
      if (it.in_byte == upd_pkg::PctChar) begin
        phase_q = upd_pkg::PhPct;
      end else begin
        dec[n] = (it.in_byte == upd_pkg::PlusChar) ? upd_pkg::SpaceChar : it.in_byte;
        n++;
      end
    end
    // end of string: flush whatever is pending literally
    if (it.in_last) begin
      if (phase_q == upd_pkg::PhPct) begin
        dec[n] = upd_pkg::PctChar;
        n++;
      end else if (phase_q == upd_pkg::PhDigit) begin
        dec[n] = upd_pkg::PctChar;
        n++;
        dec[n] = held_q;
        n++;
      end
      phase_q = upd_pkg::PhIdle;
      held_q  = 8'd0;
    end
    for (int i = 0; i < n; i++) begin
      decoded_q.push_back('{out_byte: dec[i], out_last: it.in_last && (i == n - 1)});
    end
  endtask

  // Predict on accepted source items, compare accepted out items
  always @(posedge clk_i or negedge rst_ni) begin
    upd_pkg::out_item_t want;
    if (!rst_ni) begin
      phase_q = upd_pkg::PhIdle;
      held_q  = 8'd0;
      decoded_q.delete();
      errs    = 0;
      seen    = 0;
      err_cnt_o    <= 0;
      expect_cnt_o <= 0;
      res_cnt_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_source(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected out item: out_byte %h out_last %b",
                 out_data_i.out_byte, out_data_i.out_last);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          seen++;
          if (want.out_byte !== out_data_i.out_byte) begin
            $error("out_byte mismatch: expected %h, got %h",
                   want.out_byte, out_data_i.out_byte);
            errs++;
          end
          if (want.out_last !== out_data_i.out_last) begin
            $error("out_last mismatch: expected %b, got %b",
                   want.out_last, out_data_i.out_last);
            errs++;
          end
        end
      end
      err_cnt_o    <= errs;
      expect_cnt_o <= decoded_q.size();
      res_cnt_o    <= seen;
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for url_percent_decoder
// Drives encoded strings (directed escapes, then random well-formed and
// broken escapes) under three idle profiles; the checker judges the output.
// ----------------------------------------------------------------------------
module tb;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  upd_pkg::in_item_t   in_data;
  logic                out_valid;
  logic                out_ready;
  upd_pkg::out_item_t  out_data;

  int         in_idle_pct;
  int         out_idle_pct;
  int         items_sent;
  int         strings_sent;
  int         err_cnt;
  int         expect_cnt;
  int         res_cnt;
  logic [7:0] src_q[$];

  url_percent_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  upd_decode_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .err_cnt_o    (err_cnt),
    .expect_cnt_o (expect_cnt),
    .res_cnt_o    (res_cnt)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Random hex digit, either case
  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(21);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 16) return 8'h61 + 8'(k - 10);
    return 8'h41 + 8'(k - 16);
  endfunction

  // One source item, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: l};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Send src_q as one string, end marker on its final byte
  task automatic send_src();
    for (int i = 0; i < src_q.size(); i++) begin
      send_byte(src_q[i], i == src_q.size() - 1);
    end
    strings_sent++;
  endtask

  // Hold off until every predicted byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expect_cnt != 0);
  endtask

  // Random string built from literal, '+' and escape fragments
  task automatic random_string();
    int tokens;
    int pick;
    src_q.delete();
    tokens = $urandom_range(5, 1);
    repeat (tokens) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        src_q.push_back(8'($urandom));
      end else if (pick < 40) begin
        src_q.push_back(upd_pkg::PlusChar);
      end else if (pick < 75) begin
        src_q.push_back(upd_pkg::PctChar);
        src_q.push_back(hex_char());
        src_q.push_back(hex_char());
      end else if (pick < 85) begin
        // bad second digit (mostly)
        src_q.push_back(upd_pkg::PctChar);
        src_q.push_back(hex_char());
        src_q.push_back(8'($urandom));
      end else if (pick < 92) begin
        src_q.push_back(upd_pkg::PctChar);
        src_q.push_back(8'($urandom));
      end else begin
        // unfinished escape
        src_q.push_back(upd_pkg::PctChar);
        if ($urandom_range(1) == 1) src_q.push_back(hex_char());
      end
    end
    send_src();
  endtask

  // Stimulus and verdict
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    in_idle_pct  = 32;
    out_idle_pct = 75;
    items_sent   = 0;
    strings_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero byte, plain byte, plus, all-ones byte
    src_q = {8'h00, 8'h61, upd_pkg::PlusChar, 8'hFF};
    send_src();
    // lower, mixed case and zero escapes, final one ending the string
    src_q = {upd_pkg::PctChar, 8'h36, 8'h61, upd_pkg::PctChar, 8'h46, 8'h66,
             upd_pkg::PctChar, 8'h30, 8'h30};
    send_src();
    // non-hex after '%', non-hex plus after digit, '%' after '%'
    src_q = {upd_pkg::PctChar, 8'h47, upd_pkg::PctChar, 8'h34, upd_pkg::PlusChar,
             upd_pkg::PctChar, upd_pkg::PctChar, 8'h34, 8'h31};
    send_src();
    // pending '%' flushed at the end
    src_q = {upd_pkg::PctChar};
    send_src();
    // pending '%' and digit flushed at the end
    src_q = {upd_pkg::PctChar, 8'h34};
    send_src();
    // broken escape on the final byte, three bytes out
    src_q = {upd_pkg::PctChar, 8'h34, 8'h7A};
    send_src();
    // '%' then '+' on the final byte
    src_q = {upd_pkg::PctChar, upd_pkg::PlusChar};
    send_src();

    while (items_sent < 130) random_string();
    drain();

    in_idle_pct  = 75;
    out_idle_pct = 32;
    while (items_sent < 230) random_string();
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (items_sent < 320) random_string();
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d source bytes in %0d strings, %0d decoded bytes checked,",
             items_sent, strings_sent, res_cnt);
    $display("over three idle profiles with a full drain after each.");
    if (err_cnt == 0 && expect_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_fifo.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
dv/upd_decode_check.sv
dv/tb.sv
